// ===== rtl/double_ended_queue_unit_macros.svh =====
// assertion macros for the double-ended queue unit
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define DEQU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DEQU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dequ_pkg.sv =====
// shared types and constants for the double-ended queue unit
`default_nettype none

package dequ_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned ACT_W     = 3;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned DEPTH_DEF = 256;
  localparam int unsigned CNT_W_DEF = $clog2(DEPTH_DEF + 1);

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE       = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_PUSH_BACK  = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_POP_BACK   = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CHN_HOLD,
    CHN_PUSH_HEAD,
    CHN_POP_HEAD,
    CHN_PUT_AT
  } chain_op_t;

  typedef struct packed {
    chain_op_t         op;
    logic [WORD_W-1:0] word;
  } chain_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/dequ_ifs.sv =====
// request and result channel interfaces
`default_nettype none

interface dequ_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [dequ_pkg::ACT_W-1:0]              action;
  logic signed [dequ_pkg::WORD_W-1:0]      push_value;

  modport source (output valid, output action, output push_value, input ready);
  modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface dequ_out_if #(
  parameter int unsigned CNT_W = dequ_pkg::CNT_W_DEF
);
  logic                                    valid;
  logic                                    ready;
  logic signed [dequ_pkg::WORD_W-1:0]      popped_value;
  logic [dequ_pkg::STATUS_W-1:0]           status;
  logic [CNT_W-1:0]                        entry_count;
  logic                                    is_empty;
  logic signed [dequ_pkg::WORD_W-1:0]      front_value;
  logic signed [dequ_pkg::WORD_W-1:0]      back_value;

  modport source (
    output valid, output popped_value, output status, output entry_count,
    output is_empty, output front_value, output back_value, input ready
  );
  modport sink (
    input valid, input popped_value, input status, input entry_count,
    input is_empty, input front_value, input back_value, output ready
  );
endinterface

`default_nettype wire

// ===== rtl/dequ_cell.sv =====
// one storage cell of the word chain
`default_nettype none

module dequ_cell #(
  parameter int unsigned DEPTH = dequ_pkg::DEPTH_DEF,
  parameter int unsigned POS   = 0
) (
  input  wire logic                          clk,
  input  wire dequ_pkg::chain_cmd_t          cmd,
  input  wire logic [$clog2(DEPTH)-1:0]      put_pos,
  input  wire logic [dequ_pkg::WORD_W-1:0]   lower_word,
  input  wire logic [dequ_pkg::WORD_W-1:0]   upper_word,
  output logic      [dequ_pkg::WORD_W-1:0]   word
);
  import dequ_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] MY_POS = IDX_W'(POS);

  logic [WORD_W-1:0] word_next;

  always_comb begin
    word_next = word;
    case (cmd.op)
      CHN_PUSH_HEAD: word_next = lower_word;
      CHN_POP_HEAD:  word_next = upper_word;
      CHN_PUT_AT: begin
        if (put_pos == MY_POS) begin
          word_next = cmd.word;
        end
      end
      default:       word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

`default_nettype wire

// ===== rtl/dequ_chain.sv =====
// row of cells with a fixed head end, shifting toward or away from the head or writing one cell in place
`default_nettype none

module dequ_chain #(
  parameter int unsigned DEPTH = dequ_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire dequ_pkg::chain_cmd_t          cmd,
  input  wire logic [$clog2(DEPTH)-1:0]      put_pos,
  output logic      [dequ_pkg::WORD_W-1:0]   head_word,
  output logic      [dequ_pkg::WORD_W-1:0]   second_word
);
  import dequ_pkg::*;

  logic [WORD_W-1:0] words [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] lower;
    logic [WORD_W-1:0] upper;

    if (i == 0) begin : g_first
      assign lower = cmd.word;
    end else begin : g_mid_lo
      assign lower = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper = words[i];
    end else begin : g_mid_hi
      assign upper = words[i+1];
    end

    dequ_cell #(
      .DEPTH (DEPTH),
      .POS   (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .put_pos    (put_pos),
      .lower_word (lower),
      .upper_word (upper),
      .word       (words[i])
    );
  end

  assign head_word   = words[0];
  assign second_word = words[1];

endmodule

`default_nettype wire

// ===== rtl/double_ended_queue_unit.sv =====
// an accepted request has its result in the output register in the next cycle
// throughput: one request per cycle while the result side takes results
// the output register is the only stage; a new request enters as the old result leaves
// reset clears the entry count and the output valid; stored words are not cleared
// two mirrored cell rows keep the front word and the back word each at a fixed cell
`default_nettype none
`include "double_ended_queue_unit_macros.svh"

module double_ended_queue_unit #(
  parameter int unsigned DEPTH = dequ_pkg::DEPTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  dequ_in_if.sink   in_ch,
  dequ_out_if.source out_ch
);
  import dequ_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              out_valid;
  logic              accept;

  logic [WORD_W-1:0] fwd_head, fwd_second;
  logic [WORD_W-1:0] rev_head, rev_second;
  chain_cmd_t        fwd_cmd, rev_cmd;
  logic [IDX_W-1:0]  put_pos;

  logic              is_push, is_pop, is_full, is_none_left;
  logic [WORD_W-1:0] popped_next, front_next, back_next;
  status_t           status_next;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_full     = (count == FULL_CNT);
  assign is_none_left = (count == '0);
  assign put_pos     = count[IDX_W-1:0];

  always_comb begin
    fwd_cmd      = '{op: CHN_HOLD, word: in_ch.push_value};
    rev_cmd      = '{op: CHN_HOLD, word: in_ch.push_value};
    count_next   = count;
    status_next  = ST_OK;
    popped_next  = '0;
    front_next   = fwd_head;
    back_next    = rev_head;
    is_push      = 1'b0;
    is_pop       = 1'b0;
    unique case (in_ch.action)
      ACT_PUSH_FRONT: begin
        is_push = 1'b1;
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          fwd_cmd.op = CHN_PUSH_HEAD;
          rev_cmd.op = CHN_PUT_AT;
          count_next = count + 1'b1;
          front_next = in_ch.push_value;
          if (is_none_left) begin
            back_next = in_ch.push_value;
          end
        end
      end
      ACT_PUSH_BACK: begin
        is_push = 1'b1;
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          fwd_cmd.op = CHN_PUT_AT;
          rev_cmd.op = CHN_PUSH_HEAD;
          count_next = count + 1'b1;
          back_next  = in_ch.push_value;
          if (is_none_left) begin
            front_next = in_ch.push_value;
          end
        end
      end
      ACT_POP_FRONT: begin
        is_pop = 1'b1;
        if (is_none_left) begin
          status_next = ST_EMPTY;
        end else begin
          fwd_cmd.op  = CHN_POP_HEAD;
          count_next  = count - 1'b1;
          popped_next = fwd_head;
          front_next  = fwd_second;
        end
      end
      ACT_POP_BACK: begin
        is_pop = 1'b1;
        if (is_none_left) begin
          status_next = ST_EMPTY;
        end else begin
          rev_cmd.op  = CHN_POP_HEAD;
          count_next  = count - 1'b1;
          popped_next = rev_head;
          back_next   = rev_second;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
    if (!accept) begin
      fwd_cmd.op = CHN_HOLD;
      rev_cmd.op = CHN_HOLD;
    end
  end

  dequ_chain #(.DEPTH(DEPTH)) u_fwd_chain (
    .clk         (clk),
    .cmd         (fwd_cmd),
    .put_pos     (put_pos),
    .head_word   (fwd_head),
    .second_word (fwd_second)
  );

  dequ_chain #(.DEPTH(DEPTH)) u_rev_chain (
    .clk         (clk),
    .cmd         (rev_cmd),
    .put_pos     (put_pos),
    .head_word   (rev_head),
    .second_word (rev_second)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.popped_value <= popped_next;
      out_ch.status       <= status_next;
      out_ch.entry_count  <= count_next;
      out_ch.is_empty     <= (count_next == '0);
      out_ch.front_value  <= (count_next == '0) ? '0 : front_next;
      out_ch.back_value   <= (count_next == '0) ? '0 : back_next;
    end
  end

  assign out_ch.valid = out_valid;

  `DEQU_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= FULL_CNT, "entry count above depth")
  `DEQU_ASSERT_NEXT(a_push_grows, clk, rst, accept && is_push && !is_full, count == $past(count) + 1'b1, "push did not add a word")
  `DEQU_ASSERT_NEXT(a_pop_empty, clk, rst, accept && is_pop && is_none_left, out_ch.status == ST_EMPTY && count == '0, "pop on empty queue not flagged")
  `DEQU_ASSERT_SAME(a_full_status, clk, rst, out_valid && out_ch.status == ST_FULL, out_ch.entry_count == FULL_CNT, "full status with room left")

endmodule

`default_nettype wire
